// File: rtl/cps_pkg.sv
// Shared types and constants for the CPU phase sequencer.
// Used by every module of the block; depends on nothing.
package cps_pkg;

    localparam int TIMER_BITS = 20;
    localparam int SUM_W      = 33;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_W      = 20;
    localparam int BTN_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_PULSE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY      = 4'd7;

    localparam logic [1:0] RUN_IDLE   = 2'd0;
    localparam logic [1:0] RUN_CONT   = 2'd1;
    localparam logic [1:0] RUN_CYCLE  = 2'd2;
    localparam logic [1:0] RUN_STEP   = 2'd3;

    localparam logic [BTN_W-1:0] BTN_NONE   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_ACTION = 2'd1;
    localparam logic [BTN_W-1:0] BTN_CYCLE  = 2'd2;
    localparam logic [BTN_W-1:0] BTN_STEP   = 2'd3;

    localparam logic [2:0] LAST_PHASE = 3'd5;

    // Line bits: 0 pc_increment, 1 freeze_word, 2 op_freeze, 3 hold,
    // 4 register_override, 5 store.
    localparam logic [5:0] LINES_PULSE = 6'h10;
    localparam logic [5:0] PHASE_LINES [8] = '{
        6'h02, 6'h04, 6'h09, 6'h11, 6'h00, 6'h20, 6'h00, 6'h00
    };

    typedef struct packed {
        logic mode;
        logic act_press;
        logic cyc_press;
        logic stp_press;
        logic slow;
        logic brk;
    } item_t;

    typedef struct packed {
        logic [19:0] debounce;
        logic [9:0]  board;
        logic [19:0] slow_step;
        logic [9:0]  packet;
        logic [19:0] pulse;
        logic [19:0] post_pulse;
        logic [19:0] settle;
        logic [19:0] entry;
    } cfg_t;

endpackage

// File: rtl/cpu_phase_sequencer.sv
// Top level of the CPU phase sequencer: timing registers, input stage, queue and sequencer.
// Depends on cps_pkg, cps_front, cps_queue and cps_back.
//
//   channel  direction  ports                         contents
//   s_       in         s_tvalid s_tready s_tdata     one tick of sampled pin levels
//   m_       out        m_tvalid m_tready m_tdata     control lines and run state for that tick
//   cfg_     in         cfg_valid cfg_ready cfg_index cfg_data   timing register write
//
// One tick is accepted every cycle while the result channel is not stalled; each tick yields one
// result, registered in turn by the input register, the queue and the sequencer's output register.
// Reset loads the default timings and starts the power-up pulse sequence.
// A stalled result holds the sequencer; the queue and input register absorb up to
// three further ticks before s_tready drops. Configuration writes are taken every cycle.
module cpu_phase_sequencer
    import cps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Bits from 0: mode_level, action_level, cycle_level, step_level, delay_level,
    // break_level, then two zero bits.
    input  logic [7:0]           s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Bits from 0: pc_increment, freeze_word, op_freeze, hold, register_override,
    // store, run_state (two bits).
    output logic [7:0]           m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t  cfg_reg;
    logic  front_valid;
    logic  front_ready;
    item_t front_item;
    logic  queue_valid;
    logic  queue_ready;
    item_t queue_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce   <= 20'd50000;
            cfg_reg.board      <= 10'd2;
            cfg_reg.slow_step  <= 20'd25000;
            cfg_reg.packet     <= 10'd12;
            cfg_reg.pulse      <= 20'd1000;
            cfg_reg.post_pulse <= 20'd10000;
            cfg_reg.settle     <= 20'd100000;
            cfg_reg.entry      <= 20'd500000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEBOUNCE:   cfg_reg.debounce   <= cfg_data;
                CFG_BOARD:      cfg_reg.board      <= cfg_data[9:0];
                CFG_SLOW_STEP:  cfg_reg.slow_step  <= cfg_data;
                CFG_PACKET:     cfg_reg.packet     <= cfg_data[9:0];
                CFG_PULSE:      cfg_reg.pulse      <= cfg_data;
                CFG_POST_PULSE: cfg_reg.post_pulse <= cfg_data;
                CFG_SETTLE:     cfg_reg.settle     <= cfg_data;
                CFG_ENTRY:      cfg_reg.entry      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    cps_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    cps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    cps_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: rtl/cps_front.sv
// Input stage: registers each pin sample and decodes it into press and request flags.
// Depends on cps_pkg.
module cps_front
    import cps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    output logic       item_valid,
    input  logic       item_ready,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg          <= 1'b1;
            item_reg.mode      <= s_tdata[0];
            item_reg.act_press <= !s_tdata[1];
            item_reg.cyc_press <= !s_tdata[2];
            item_reg.stp_press <= !s_tdata[3];
            item_reg.slow      <= !s_tdata[4];
            item_reg.brk       <= !s_tdata[5];
        end else if (item_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// File: rtl/cps_queue.sv
// Two-entry queue of decoded samples between the input stage and the sequencer.
// Depends on cps_pkg.
module cps_queue
    import cps_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/cps_back.sv
// Sequencer: runs the power-up, manual, run, break and button qualification steps, one sample a cycle
// while its output is not stalled, and holds the result in an output register. Depends on cps_pkg.
module cps_back
    import cps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    typedef enum logic [4:0] {
        ST_BOOT     = 5'd0,
        ST_PU_WAIT  = 5'd1,
        ST_PU_P1    = 5'd2,
        ST_PU_G1    = 5'd3,
        ST_PU_P2    = 5'd4,
        ST_PU_G2    = 5'd5,
        ST_TOP      = 5'd6,
        ST_LV_W1    = 5'd7,
        ST_LV_P     = 5'd8,
        ST_LV_W2    = 5'd9,
        ST_MAN_P    = 5'd10,
        ST_MAN_G    = 5'd11,
        ST_BRK      = 5'd12,
        ST_BRK_SET  = 5'd13,
        ST_ENTRY    = 5'd14,
        ST_SEL      = 5'd15,
        ST_PHASE    = 5'd16,
        ST_CONT_ACT = 5'd17,
        ST_SS_PH    = 5'd18,
        ST_SS_WAIT  = 5'd19,
        ST_QD1      = 5'd20,
        ST_QH       = 5'd21,
        ST_QD2      = 5'd22
    } step_t;

    typedef struct packed {
        step_t                 step;
        logic [TIMER_BITS-1:0] wait_cnt;
        logic [1:0]            run;
        logic [2:0]            phase;
        logic [BTN_W-1:0]      pend;
    } nx_t;

    localparam logic [SUM_W-1:0] TMASK = (SUM_W'(1) << TIMER_BITS) - SUM_W'(1);
    localparam logic [TIMER_BITS-1:0] W_ZERO = '0;

    function automatic logic [TIMER_BITS-1:0] sat_ticks(input logic [SUM_W-1:0] v);
        logic [TIMER_BITS-1:0] r;
        if (v > TMASK) begin
            r = TMASK[TIMER_BITS-1:0];
        end else begin
            r = v[TIMER_BITS-1:0];
        end
        return r;
    endfunction

    step_t                 step_reg;
    logic [TIMER_BITS-1:0] wait_reg;
    logic [1:0]            run_reg;
    logic [2:0]            phase_reg;
    logic                  prev_reg;
    logic [BTN_W-1:0]      pend_reg;
    logic                  m_valid_reg;
    logic [7:0]            m_data_reg;

    nx_t                   cur;
    nx_t                   nx;
    nx_t                   start_nx;
    nx_t                   sel_nx;
    nx_t                   disp_nx;
    nx_t                   entry_nx;
    nx_t                   qd_nx;
    logic                  prev_next;
    logic                  advance;
    logic                  released;
    logic                  qual_ok;
    logic [2:0]            pt_phase;
    logic [SUM_W-1:0]      pt_sum;
    logic [TIMER_BITS-1:0] w_pt;
    logic [TIMER_BITS-1:0] w_deb;
    logic [TIMER_BITS-1:0] w_pkt;
    logic [TIMER_BITS-1:0] w_pulse;
    logic [TIMER_BITS-1:0] w_post;
    logic [TIMER_BITS-1:0] w_settle;
    logic [TIMER_BITS-1:0] w_entry;
    logic [5:0]            lines;

    assign advance    = item_valid && (!m_valid_reg || m_tready);
    assign item_ready = advance;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    assign w_deb    = sat_ticks(SUM_W'(cfg.debounce));
    assign w_pkt    = sat_ticks(SUM_W'(cfg.packet));
    assign w_pulse  = sat_ticks(SUM_W'(cfg.pulse));
    assign w_post   = sat_ticks(SUM_W'(cfg.post_pulse));
    assign w_settle = sat_ticks(SUM_W'(cfg.settle));
    assign w_entry  = sat_ticks(SUM_W'(cfg.entry));

    always_comb begin
        pt_phase = (step_reg == ST_PHASE) ? phase_reg + 3'd1 : 3'd0;
        pt_sum   = SUM_W'(cfg.board) + (item.slow ? SUM_W'(cfg.slow_step) : '0);
        if (pt_phase < 3'd2) begin
            pt_sum = pt_sum + SUM_W'(cfg.packet[9:1]);
        end else if (pt_phase == LAST_PHASE) begin
            pt_sum = pt_sum + SUM_W'(cfg.packet);
        end
        w_pt = sat_ticks(pt_sum);
    end

    always_comb begin
        case (pend_reg)
            BTN_ACTION: released = !item.act_press;
            BTN_CYCLE:  released = !item.cyc_press;
            BTN_STEP:   released = !item.stp_press;
            default:    released = 1'b1;
        endcase
        qual_ok = released && (step_reg == ST_QD2);
    end

    always_comb begin
        cur = '{step: step_reg, wait_cnt: wait_reg, run: run_reg,
                phase: phase_reg, pend: pend_reg};

        start_nx       = cur;
        start_nx.phase = 3'd0;
        if (run_reg == RUN_STEP) begin
            start_nx.step     = ST_SS_PH;
            start_nx.wait_cnt = w_pkt;
        end else begin
            start_nx.step     = ST_PHASE;
            start_nx.wait_cnt = w_pt;
        end

        sel_nx          = cur;
        sel_nx.step     = ST_QD1;
        sel_nx.wait_cnt = w_deb;
        if (item.act_press) begin
            sel_nx.pend = BTN_ACTION;
        end else if (item.cyc_press) begin
            sel_nx.pend = BTN_CYCLE;
        end else if (item.stp_press) begin
            sel_nx.pend = BTN_STEP;
        end else begin
            sel_nx.step     = ST_TOP;
            sel_nx.wait_cnt = W_ZERO;
        end

        disp_nx = (run_reg == RUN_IDLE) ? sel_nx : start_nx;

        entry_nx = disp_nx;
        if (!prev_reg) begin
            entry_nx          = cur;
            entry_nx.step     = ST_ENTRY;
            entry_nx.wait_cnt = w_entry;
        end

        qd_nx          = cur;
        qd_nx.pend     = BTN_NONE;
        qd_nx.wait_cnt = W_ZERO;
        if (run_reg == RUN_STEP) begin
            if (!qual_ok) begin
                qd_nx.step = ST_SS_WAIT;
            end else if (phase_reg < LAST_PHASE) begin
                qd_nx.phase    = phase_reg + 3'd1;
                qd_nx.step     = ST_SS_PH;
                qd_nx.wait_cnt = w_pkt;
            end else begin
                qd_nx.run   = RUN_IDLE;
                qd_nx.phase = 3'd0;
                qd_nx.step  = ST_TOP;
            end
        end else if (run_reg != RUN_IDLE) begin
            if (qual_ok) begin
                qd_nx.run   = RUN_IDLE;
                qd_nx.phase = 3'd0;
                qd_nx.step  = ST_TOP;
            end else begin
                qd_nx.step = ST_CONT_ACT;
            end
        end else if (!prev_reg) begin
            if (qual_ok) begin
                qd_nx.step     = ST_MAN_P;
                qd_nx.wait_cnt = w_pulse;
            end else begin
                qd_nx.step = ST_TOP;
            end
        end else if (qual_ok) begin
            qd_nx.run = pend_reg;
            if (pend_reg == BTN_NONE) begin
                qd_nx.step = ST_TOP;
            end else begin
                qd_nx.phase = 3'd0;
                if (pend_reg == BTN_STEP) begin
                    qd_nx.step     = ST_SS_PH;
                    qd_nx.wait_cnt = w_pkt;
                end else begin
                    qd_nx.step     = ST_PHASE;
                    qd_nx.wait_cnt = w_pt;
                end
            end
        end else begin
            qd_nx.step = ST_SEL;
        end
    end

    always_comb begin
        nx        = cur;
        prev_next = prev_reg;
        if (wait_reg != W_ZERO) begin
            nx.wait_cnt = wait_reg - TIMER_BITS'(1);
        end else begin
            unique case (step_reg)
                ST_BOOT: begin
                    nx.step = ST_PU_WAIT; nx.wait_cnt = w_entry;
                end
                ST_PU_WAIT: begin
                    nx.step = ST_PU_P1; nx.wait_cnt = w_pulse;
                end
                ST_PU_P1: begin
                    nx.step = ST_PU_G1; nx.wait_cnt = w_post;
                end
                ST_PU_G1: begin
                    nx.step = ST_PU_P2; nx.wait_cnt = w_pulse;
                end
                ST_PU_P2: begin
                    nx.step = ST_PU_G2; nx.wait_cnt = w_settle;
                end
                ST_LV_W1: begin
                    nx.step = ST_LV_P; nx.wait_cnt = w_pulse;
                end
                ST_LV_P: begin
                    nx.step = ST_LV_W2; nx.wait_cnt = w_settle;
                end
                ST_LV_W2: begin
                    prev_next = 1'b0;
                    if (item.act_press) begin
                        nx.step = ST_QD1; nx.wait_cnt = w_deb; nx.pend = BTN_ACTION;
                    end else begin
                        nx.step = ST_TOP;
                    end
                end
                ST_MAN_P: begin
                    nx.step = ST_MAN_G; nx.wait_cnt = w_post;
                end
                ST_BRK: begin
                    if (!item.brk) begin
                        nx = entry_nx;
                    end else begin
                        nx.run = RUN_IDLE; nx.step = ST_BRK_SET; nx.wait_cnt = w_settle;
                    end
                end
                ST_BRK_SET: nx = entry_nx;
                ST_ENTRY: begin
                    prev_next = 1'b1;
                    nx        = disp_nx;
                end
                ST_SEL: nx = sel_nx;
                ST_PHASE: begin
                    if (phase_reg < LAST_PHASE) begin
                        nx.phase = phase_reg + 3'd1; nx.wait_cnt = w_pt;
                    end else if (run_reg == RUN_CONT) begin
                        if (item.act_press) begin
                            nx.step = ST_QD1; nx.wait_cnt = w_deb; nx.pend = BTN_ACTION;
                        end else begin
                            nx.step = ST_CONT_ACT;
                        end
                    end else begin
                        nx.run = RUN_IDLE; nx.phase = 3'd0; nx.step = ST_TOP;
                    end
                end
                ST_CONT_ACT: begin
                    if (item.act_press) begin
                        nx.step = ST_QD1; nx.wait_cnt = w_deb; nx.pend = BTN_ACTION;
                    end else begin
                        nx.phase = 3'd0; nx.step = ST_TOP;
                    end
                end
                ST_SS_PH: nx.step = ST_SS_WAIT;
                ST_SS_WAIT: begin
                    if (item.stp_press) begin
                        nx.step = ST_QD1; nx.wait_cnt = w_deb; nx.pend = BTN_STEP;
                    end
                end
                ST_QD1: begin
                    if (released) begin
                        nx = qd_nx;
                    end else begin
                        nx.step = ST_QH;
                    end
                end
                ST_QH: begin
                    if (released) begin
                        nx.step = ST_QD2; nx.wait_cnt = w_deb;
                    end
                end
                ST_QD2: nx = qd_nx;
                default: begin
                    if (!item.mode) begin
                        nx.run   = RUN_IDLE;
                        nx.phase = 3'd0;
                        if (prev_reg) begin
                            nx.step = ST_LV_W1; nx.wait_cnt = w_settle;
                        end else if (item.act_press) begin
                            nx.step = ST_QD1; nx.wait_cnt = w_deb; nx.pend = BTN_ACTION;
                        end else begin
                            nx.step = ST_TOP;
                        end
                    end else if (item.brk && run_reg != RUN_IDLE) begin
                        nx.step = ST_BRK; nx.wait_cnt = w_deb;
                    end else begin
                        nx = entry_nx;
                    end
                end
            endcase
        end
    end

    always_comb begin
        case (nx.step)
            ST_PU_P1, ST_PU_P2, ST_LV_P, ST_MAN_P: lines = LINES_PULSE;
            ST_PHASE, ST_CONT_ACT, ST_SS_PH, ST_SS_WAIT, ST_QD1, ST_QH, ST_QD2:
                lines = (nx.run != RUN_IDLE) ? PHASE_LINES[nx.phase] : 6'h00;
            default: lines = 6'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_BOOT;
            wait_reg    <= W_ZERO;
            run_reg     <= RUN_IDLE;
            phase_reg   <= 3'd0;
            prev_reg    <= 1'b0;
            pend_reg    <= BTN_NONE;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            step_reg    <= nx.step;
            wait_reg    <= nx.wait_cnt;
            run_reg     <= nx.run;
            phase_reg   <= nx.phase;
            prev_reg    <= prev_next;
            pend_reg    <= nx.pend;
            m_valid_reg <= 1'b1;
            m_data_reg  <= {nx.run, lines};
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule
